// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 11;
  localparam int OCNT_W = 11;
  localparam int WORD_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [OCNT_W-1:0]        entry_count;
  } rsp_t;

  // one write request into the ring store
  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_t;

  // (a + b) mod DEPTH for a < DEPTH, b <= DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  // capacity saturated at DEPTH
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    if (32'(cap) > 32'(DEPTH)) return CNT_W'(DEPTH);
    return CNT_W'(cap);
  endfunction

endpackage

// ===== hdl/bdq_ring_store.sv =====
module bdq_ring_store import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  wr_t               wr,
  input  logic [PTR_W-1:0]  ra0,
  input  logic [PTR_W-1:0]  ra1,
  output logic [WORD_W-1:0] rd0,
  output logic [WORD_W-1:0] rd1
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] q0;
  logic [WORD_W-1:0] q1;
  logic [WORD_W-1:0] byp;
  logic              hit0;
  logic              hit1;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  // reads see the write of the same cycle through the bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0   <= mem[ra0];
      q1   <= mem[ra1];
      hit0 <= wr.en && (wr.addr == ra0);
      hit1 <= wr.en && (wr.addr == ra1);
      byp  <= wr.data;
    end
  end

  assign rd0 = hit0 ? byp : q0;
  assign rd1 = hit1 ? byp : q1;

endmodule

// ===== hdl/bounded_double_ended_queue_core.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data  (req_t: opcode, data_value)
// out       output     out_valid / out_ready  out_data (rsp_t: queue view after op)
// cfg       input      cfg_wr_en              cfg_wr_data (capacity)
//
// One request per cycle unless the output stalls; the result is registered in
// the result stage. Stage 1 holds the request; its update of head/count and
// the store write and two reads happen at the edge into the result stage (store
// read port is the second register). Reset clears head, count, capacity (to
// 1024) and valids; the store is not cleared. An output stall holds the result;
// stage 1 still takes one request while empty, then in_ready drops.
module bounded_double_ended_queue_core import bdq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  logic [CAP_W-1:0] capacity;

  // stage 1: request register
  logic s1_valid;
  req_t s1_req;

  // queue state
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;

  // result stage
  logic             res_acc;
  logic [CNT_W-1:0] res_count;
  logic             res_full;

  logic             adv;
  logic             ok;
  logic [CNT_W-1:0] cap;
  wr_t              wr;
  logic [PTR_W-1:0] ra_front, ra_rear;
  logic [WORD_W-1:0] rd_front, rd_rear;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign cap      = eff_cap(capacity);

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (cfg_wr_en) capacity <= cfg_wr_data;
  end

  // op decode and next state
  always_comb begin
    head_next = head;
    count_next = count;
    ok = 1'b0;
    wr.en = 1'b0;
    wr.addr = ring_add(head, count);
    wr.data = s1_req.data_value;
    case (s1_req.opcode)
      OP_PUSH_FRONT: begin
        if (count < cap) begin
          head_next = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
          wr.addr = head_next;
          wr.en = 1'b1;
          count_next = count + 1'b1;
          ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count < cap) begin
          wr.en = 1'b1;
          count_next = count + 1'b1;
          ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count != '0) begin
          head_next = ring_add(head, CNT_W'(1));
          count_next = count - 1'b1;
          ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count != '0) begin
          count_next = count - 1'b1;
          ok = 1'b1;
        end
      end
      OP_QUERY: ok = 1'b1;
      default: ok = 1'b0;  // unknown op: no effect, refused
    endcase
    // only commit when the request moves into the result stage
    wr.en = wr.en && s1_valid && adv;
  end

  assign ra_front = head_next;
  assign ra_rear  = (count_next == '0) ? head_next
                                       : ring_add(head_next, count_next - 1'b1);

  bdq_ring_store u_store (
    .clk   (clk),
    .rd_en (s1_valid && adv),
    .wr    (wr),
    .ra0   (ra_front),
    .ra1   (ra_rear),
    .rd0   (rd_front),
    .rd1   (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      head      <= '0;
      count     <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          head  <= head_next;
          count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_req <= in_data;
    if (adv && s1_valid) begin
      res_acc   <= ok;
      res_count <= count_next;
      res_full  <= count_next >= cap;
    end
  end

  always_comb begin
    out_data.accepted    = res_acc;
    out_data.is_empty    = (res_count == '0);
    out_data.is_full     = res_full;
    out_data.entry_count = OCNT_W'(res_count);
    out_data.front_value = (res_count == '0) ? EMPTY_WORD : rd_front;
    out_data.rear_value  = (res_count == '0) ? EMPTY_WORD : rd_rear;
  end

endmodule

// ===== hdl/bdq_checker.sv =====
module bdq_checker import bdq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input req_t in_data,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // empty view is consistent
  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |->
      out_data.entry_count == '0 && out_data.front_value == -1 &&
      out_data.rear_value == -1)
    else $error("empty result with data or count");

  // count never exceeds the ring and agrees with the empty flag
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.entry_count) <= 32'(DEPTH) &&
      out_data.is_empty == (out_data.entry_count == '0))
    else $error("entry count out of range");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (.*);
